// ===== hdl/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// LU solver package
// Shared constants and widths for the LU linear system solver.
// ----------------------------------------------------------------------------
package lss_pkg;
   localparam int MaxOrder   = 8;
   localparam int RowStride  = MaxOrder + 1;
   localparam int StoreDepth = MaxOrder * RowStride;
   localparam int AddrWidth  = $clog2(StoreDepth);
   localparam int IdxWidth   = $clog2(RowStride);
   localparam int PosWidth   = $clog2(MaxOrder);
   localparam int DataWidth  = 32;
   localparam logic signed [DataWidth-1:0] SatHi = {1'b0, {(DataWidth-1){1'b1}}};
   localparam logic signed [DataWidth-1:0] SatLo = {1'b1, {(DataWidth-1){1'b0}}};

   typedef logic signed [DataWidth-1:0] word_type;

   function automatic word_type sat64(input logic signed [63:0] v);
      word_type r;
      if (v > 64'(SatHi)) r = SatHi;
      else if (v < 64'(SatLo)) r = SatLo;
      else r = v[DataWidth-1:0];
      return r;
   endfunction

   function automatic logic [AddrWidth-1:0] addr_of(input logic [IdxWidth-1:0] r,
                                                     input logic [IdxWidth-1:0] c);
      logic [AddrWidth+IdxWidth:0] t;
      t = ((AddrWidth+IdxWidth+1)'(r) * (AddrWidth+IdxWidth+1)'(RowStride))
          + (AddrWidth+IdxWidth+1)'(c);
      return t[AddrWidth-1:0];
   endfunction
endpackage

// ===== hdl/lss_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module lss_ram #(
   parameter int Width = 32,
   parameter int Depth = 72
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== hdl/lss_divider.sv =====
// ----------------------------------------------------------------------------
// Q16.16 divider
// Restoring divider, one quotient bit per cycle, saturated signed result.
// ----------------------------------------------------------------------------
module lss_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  lss_pkg::word_type       num,
   input  lss_pkg::word_type       den,
   output logic                    done,
   output lss_pkg::word_type       quo
);
   import lss_pkg::*;
   localparam int NumBits = DataWidth + 16;

   logic [NumBits-1:0] dvd_ff;
   logic [NumBits-1:0] q_ff;
   logic [NumBits:0]   rem_ff;
   logic [DataWidth-1:0] dvs_ff;
   logic                 neg_ff;
   logic [$clog2(NumBits+1)-1:0] cnt_ff;
   logic                 busy_ff;
   logic [NumBits:0]     shifted;
   logic [NumBits:0]     diff;
   logic [NumBits-1:0]   a_abs;
   logic [DataWidth-1:0] d_abs;
   logic signed [63:0]   sq;

   assign a_abs = num[DataWidth-1] ? NumBits'(-{{16{num[DataWidth-1]}}, num}) << 16
                                   : NumBits'({{16{1'b0}}, num}) << 16;
   assign d_abs = den[DataWidth-1] ? DataWidth'(-den) : DataWidth'(den);
   assign shifted = {rem_ff[NumBits-1:0], dvd_ff[NumBits-1]};
   assign diff    = shifted - (NumBits+1)'(dvs_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= ($clog2(NumBits+1))'(NumBits);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == 1) begin
               busy_ff <= 1'b0;
               done    <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= a_abs;
         dvs_ff <= d_abs;
         rem_ff <= '0;
         q_ff   <= '0;
         neg_ff <= num[DataWidth-1] ^ den[DataWidth-1];
      end else if (busy_ff) begin
         dvd_ff <= dvd_ff << 1;
         if (!diff[NumBits]) begin
            rem_ff <= diff;
            q_ff   <= {q_ff[NumBits-2:0], 1'b1};
         end else begin
            rem_ff <= shifted;
            q_ff   <= {q_ff[NumBits-2:0], 1'b0};
         end
      end
   end

   assign sq  = neg_ff ? -$signed(64'(q_ff)) : $signed(64'(q_ff));
   assign quo = sat64(sq);
endmodule

// ===== hdl/lu_linear_system_solver.sv =====
// ----------------------------------------------------------------------------
// LU linear system solver
// Doolittle elimination and back substitution without pivoting, Q16.16.
// ----------------------------------------------------------------------------
// Load n*(n+1) values row-major, one per cycle; the last one starts the solve
// and req_stall stays high until all n results have been taken. The solve runs
// on one shared multiplier and one shared bit-serial divider over a store with
// one write port and one registered read port, so a run of order n takes about
// n^3/2 multiply-subtract steps plus about n^2/2 divisions.
module lu_linear_system_solver (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  lss_pkg::word_type                req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output lss_pkg::word_type                rsp_solution,
   output logic [lss_pkg::PosWidth-1:0]     rsp_position,
   output logic                             rsp_final_flag,
   output logic                             rsp_singular,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [1:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import lss_pkg::*;

   localparam logic [3:0] StLoad  = 4'd0;
   localparam logic [3:0] StPiv   = 4'd1;
   localparam logic [3:0] StKrd   = 4'd2;
   localparam logic [3:0] StKdiv  = 4'd3;
   localparam logic [3:0] StErdI  = 4'd4;
   localparam logic [3:0] StErdR  = 4'd5;
   localparam logic [3:0] StEwr   = 4'd6;
   localparam logic [3:0] StBacc  = 4'd7;
   localparam logic [3:0] StBrd   = 4'd8;
   localparam logic [3:0] StBmac  = 4'd9;
   localparam logic [3:0] StBpiv  = 4'd10;
   localparam logic [3:0] StBdiv  = 4'd11;
   localparam logic [3:0] StOut   = 4'd12;
   localparam logic [3:0] StWait  = 4'd13;
   localparam logic [1:0] RegSize = 2'd0;

   logic [3:0]          state_ff;
   logic [3:0]          size_ff;
   logic [IdxWidth-1:0] n;
   logic [IdxWidth-1:0] row_ff, col_ff, i_ff, f_ff;
   logic [AddrWidth-1:0] rd_addr, wr_addr;
   logic                wr_en;
   word_type            wr_data, rd_data;
   word_type            piv_ff, k_ff, acc_ff, tmp_ff, prod_ff;
   word_type            x_ff [MaxOrder];
   logic                sing_ff;
   logic [PosWidth:0]   out_ff;
   logic                div_start, div_done;
   word_type            div_num, div_den, div_q;
   logic                wait_ff;
   logic signed [63:0]  mul_full;
   logic signed [63:0]  mul_q;
   logic                load_last;
   logic                csr_wr;
   logic                elim_mode;

   always_comb begin
      if (size_ff == 4'd0) n = IdxWidth'(1);
      else if (size_ff > 4'(MaxOrder)) n = IdxWidth'(MaxOrder);
      else n = size_ff[IdxWidth-1:0];
   end

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == RegSize) ? {28'd0, size_ff} : 32'd0;

   assign req_stall = (state_ff != StLoad);
   assign load_last = (row_ff == n - 1'b1) && (col_ff == n);

   lss_ram #(.Width(DataWidth), .Depth(StoreDepth)) u_store (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   lss_divider u_div (
      .clock, .reset, .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quo(div_q)
   );

   assign mul_full = 64'(k_ff) * 64'(rd_data);
   assign mul_q    = mul_full / 65536;

   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = addr_of(row_ff, col_ff);
      wr_data   = req_value;
      rd_addr   = addr_of(row_ff, col_ff);
      div_start = 1'b0;
      div_num   = tmp_ff;
      div_den   = piv_ff;
      elim_mode = 1'b0;
      unique case (state_ff)
         StLoad:  wr_en = req_valid;
         StPiv:   rd_addr = addr_of(i_ff, i_ff);
         StKrd:   rd_addr = addr_of(row_ff, i_ff);
         StKdiv:  div_start = !wait_ff;
         StErdI:  rd_addr = addr_of(i_ff, f_ff);
         StErdR:  rd_addr = addr_of(row_ff, f_ff);
         StEwr: begin
            elim_mode = 1'b1;
            wr_en     = 1'b1;
            wr_addr   = addr_of(row_ff, f_ff);
            wr_data   = sat64(64'(rd_data) - 64'(prod_ff));
            rd_addr   = addr_of(row_ff + 1'b1, i_ff);
         end
         StBacc:  rd_addr = addr_of(i_ff, n);
         StBrd:   rd_addr = addr_of(i_ff, f_ff);
         StBmac:  rd_addr = addr_of(i_ff, f_ff);
         StBpiv:  rd_addr = addr_of(i_ff, i_ff);
         StBdiv: begin
            div_start = !wait_ff;
            div_num   = acc_ff;
         end
         StOut, StWait: ;
         default: ;
      endcase
   end

   // k_ff doubles as the back-substitution multiplicand through x_ff.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StLoad;
         size_ff  <= 4'd8;
         row_ff   <= '0;
         col_ff   <= '0;
         i_ff     <= '0;
         f_ff     <= '0;
         sing_ff  <= 1'b0;
         out_ff   <= '0;
         wait_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            StLoad: begin
               if (csr_wr) begin
                  if (csr_paddr == RegSize) begin
                     size_ff <= csr_pwdata[3:0];
                     row_ff  <= '0;
                     col_ff  <= '0;
                  end
               end else if (req_valid) begin
                  if (load_last) begin
                     state_ff <= StPiv;
                     i_ff     <= '0;
                     sing_ff  <= 1'b0;
                     row_ff   <= '0;
                     col_ff   <= '0;
                  end else if (col_ff == n) begin
                     col_ff <= '0;
                     row_ff <= row_ff + 1'b1;
                  end else begin
                     col_ff <= col_ff + 1'b1;
                  end
               end
            end
            StPiv: begin
               state_ff <= StKrd;
               row_ff   <= i_ff + 1'b1;
               wait_ff  <= 1'b1;
            end
            StKrd: begin
               if (wait_ff) begin
                  wait_ff <= 1'b0;
                  piv_ff  <= rd_data;
                  if (rd_data == '0) sing_ff <= 1'b1;
                  if (rd_data == '0 || row_ff >= n) begin
                     if (i_ff == n - 1'b1) begin
                        state_ff <= StBacc;
                        i_ff     <= n - 1'b1;
                        wait_ff  <= 1'b1;
                     end else begin
                        i_ff     <= i_ff + 1'b1;
                        state_ff <= StPiv;
                     end
                  end else begin
                     state_ff <= StKrd;
                  end
               end else begin
                  tmp_ff   <= rd_data;
                  state_ff <= StKdiv;
               end
            end
            StKdiv: begin
               wait_ff <= 1'b1;
               if (wait_ff && div_done) begin
                  k_ff     <= div_q;
                  wait_ff  <= 1'b0;
                  f_ff     <= '0;
                  state_ff <= StErdI;
               end
            end
            StErdI: begin
               state_ff <= StErdR;
            end
            StErdR: begin
               prod_ff  <= sat64(mul_q);
               state_ff <= StEwr;
            end
            StEwr: begin
               if (f_ff == n) begin
                  if (row_ff == n - 1'b1) begin
                     if (i_ff == n - 1'b1) begin
                        state_ff <= StBacc;
                        wait_ff  <= 1'b1;
                     end else begin
                        i_ff     <= i_ff + 1'b1;
                        state_ff <= StPiv;
                     end
                  end else begin
                     row_ff   <= row_ff + 1'b1;
                     state_ff <= StKrd;
                     wait_ff  <= 1'b0;
                  end
               end else begin
                  f_ff     <= f_ff + 1'b1;
                  state_ff <= StErdI;
               end
            end
            StBacc: begin
               if (wait_ff) begin
                  wait_ff <= 1'b0;
               end else begin
                  acc_ff   <= rd_data;
                  f_ff     <= i_ff + 1'b1;
                  state_ff <= StBrd;
               end
            end
            StBrd: begin
               if (f_ff >= n) begin
                  state_ff <= StBpiv;
                  wait_ff  <= 1'b1;
               end else begin
                  k_ff     <= x_ff[f_ff[PosWidth-1:0]];
                  state_ff <= StBmac;
                  wait_ff  <= 1'b1;
               end
            end
            StBmac: begin
               if (wait_ff) begin
                  wait_ff <= 1'b0;
               end else begin
                  acc_ff   <= sat64(64'(acc_ff) - 64'(sat64(mul_q)));
                  f_ff     <= f_ff + 1'b1;
                  state_ff <= StBrd;
               end
            end
            StBpiv: begin
               if (wait_ff) begin
                  wait_ff <= 1'b0;
               end else begin
                  piv_ff <= rd_data;
                  if (rd_data == '0) begin
                     sing_ff <= 1'b1;
                     x_ff[i_ff[PosWidth-1:0]] <= '0;
                     if (i_ff == '0) begin
                        state_ff <= StOut;
                        out_ff   <= '0;
                     end else begin
                        i_ff     <= i_ff - 1'b1;
                        state_ff <= StBacc;
                        wait_ff  <= 1'b1;
                     end
                  end else begin
                     state_ff <= StBdiv;
                  end
               end
            end
            StBdiv: begin
               wait_ff <= 1'b1;
               if (wait_ff && div_done) begin
                  wait_ff <= 1'b1;
                  x_ff[i_ff[PosWidth-1:0]] <= div_q;
                  if (i_ff == '0) begin
                     state_ff <= StOut;
                     out_ff   <= '0;
                     wait_ff  <= 1'b0;
                  end else begin
                     i_ff     <= i_ff - 1'b1;
                     state_ff <= StBacc;
                  end
               end
            end
            StOut: begin
               if (!rsp_stall) begin
                  if (out_ff == (PosWidth+1)'(n - 1'b1)) begin
                     state_ff <= StLoad;
                     row_ff   <= '0;
                     col_ff   <= '0;
                  end else begin
                     out_ff <= out_ff + 1'b1;
                  end
               end
            end
            StWait: state_ff <= StLoad;
            default: state_ff <= StLoad;
         endcase
      end
   end

   assign rsp_valid      = (state_ff == StOut);
   assign rsp_position   = out_ff[PosWidth-1:0];
   assign rsp_final_flag = (out_ff == (PosWidth+1)'(n - 1'b1));
   assign rsp_singular   = sing_ff;
   assign rsp_solution   = sing_ff ? '0 : x_ff[out_ff[PosWidth-1:0]];

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != StLoad) |-> req_stall)
      else $error("input taken during solve");
   a_out_only_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == StOut) && !elim_mode)
      else $error("result outside output phase");
   a_final_then_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_final_flag) |=> (state_ff == StLoad))
      else $error("no return to load after last result");
endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// LU solver testbench
// Loads random and directed Q16.16 systems of orders 1 to 4 and 8 through the
// request channel, predicts the solution vector with a local Doolittle
// elimination and back substitution, and checks each response field against
// it while the sender idles and the receiver stalls in several patterns.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lss_pkg::*;

   localparam int SizeAddr = 0;

   typedef struct packed {
      word_type                solution;
      logic [PosWidth-1:0]     position;
      logic                    final_flag;
      logic                    singular;
   } solution_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   word_type req_value = '0;
   logic req_taken = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   word_type rsp_solution;
   logic [PosWidth-1:0] rsp_position;
   logic rsp_final_flag;
   logic rsp_singular;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   word_type value_queue[$];
   solution_type solution_queue[$];
   longint system_store[MaxOrder][RowStride];
   int order_reg = 8;
   int loaded = 0;
   int errors = 0;
   int send_idle = 0;
   int recv_stall = 0;

   lu_linear_system_solver u_dut (.*);

   always #2 clock = ~clock;

   function automatic longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint fix_mul(longint a, longint b);
      return clamp((a * b) / 65536);
   endfunction

   function automatic longint fix_div(longint a, longint p);
      return clamp((a * 65536) / p);
   endfunction

   function automatic int order_now();
      if (order_reg < 1) return 1;
      if (order_reg > MaxOrder) return MaxOrder;
      return order_reg;
   endfunction

   task automatic solve_system();
      int n;
      longint p, k, acc;
      longint x[MaxOrder];
      bit zero_pivot;
      solution_type s;
      n = order_now();
      zero_pivot = 0;
      for (int i = 0; i < n; i++) begin
         p = system_store[i][i];
         if (p == 0) begin
            zero_pivot = 1;
            continue;
         end
         for (int r = i + 1; r < n; r++) begin
            k = fix_div(system_store[r][i], p);
            for (int f = 0; f <= n; f++)
               system_store[r][f] = clamp(system_store[r][f] - fix_mul(k, system_store[i][f]));
         end
      end
      for (int i = n - 1; i >= 0; i--) begin
         acc = system_store[i][n];
         p = system_store[i][i];
         for (int f = i + 1; f < n; f++)
            acc = clamp(acc - fix_mul(system_store[i][f], x[f]));
         if (p == 0) begin
            zero_pivot = 1;
            x[i] = 0;
         end else begin
            x[i] = fix_div(acc, p);
         end
      end
      for (int i = 0; i < n; i++) begin
         s.solution = zero_pivot ? '0 : word_type'(x[i]);
         s.position = PosWidth'(i);
         s.final_flag = (i == n - 1);
         s.singular = zero_pivot;
         solution_queue.push_back(s);
      end
   endtask

   task automatic load_value(word_type v);
      int n;
      n = order_now();
      system_store[loaded / (n + 1)][loaded % (n + 1)] = longint'(v);
      loaded++;
      if (loaded == n * (n + 1)) begin
         loaded = 0;
         solve_system();
      end
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0h expected %0h", what, got, want);
   endtask

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (value_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_valid <= 1'b1;
               req_value <= value_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
               req_value <= $urandom;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall);
      end
   end

   always @(posedge clock) begin
      solution_type s;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall)
         load_value(req_value);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (solution_queue.size() == 0) begin
            report("unexpected transaction", rsp_solution, 32'd0);
         end else begin
            s = solution_queue.pop_front();
            if (rsp_solution !== s.solution) report("solution", rsp_solution, s.solution);
            if (rsp_position !== s.position)
               report("position", 32'(rsp_position), 32'(s.position));
            if (rsp_final_flag !== s.final_flag)
               report("final_flag", 32'(rsp_final_flag), 32'(s.final_flag));
            if (rsp_singular !== s.singular)
               report("singular", 32'(rsp_singular), 32'(s.singular));
         end
      end
   end

   task automatic write_size(int v);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 2'(SizeAddr);
      csr_pwdata <= 32'(v);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      order_reg = v & 15;
      loaded = 0;
   endtask

   task automatic drain();
      while (value_queue.size() > 0 || req_valid || solution_queue.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic word_type random_value();
      case ($urandom_range(5))
         0: return word_type'($urandom);
         1: return SatHi;
         2: return SatLo;
         3: return '0;
         default: return word_type'($signed($urandom_range(32'h60000)) - 32'sh30000);
      endcase
   endfunction

   task automatic queue_system(int n, int kind);
      for (int r = 0; r < n; r++)
         for (int c = 0; c <= n; c++)
            case (kind)
               0: value_queue.push_back(random_value());
               1: value_queue.push_back(r == c ? word_type'(32'sh10000 * (r + 2))
                                               : word_type'($signed($urandom_range(32'h20000))
                                                            - 32'sh10000));
               default: value_queue.push_back(r == c ? '0 : word_type'($urandom));
            endcase
   endtask

   initial begin
      int n, sent;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: extremes, singular, clamped sizes
      write_size(1);
      value_queue.push_back(SatHi); value_queue.push_back(SatLo);
      value_queue.push_back(32'sh10000); value_queue.push_back(32'sh7fffffff);
      value_queue.push_back('0); value_queue.push_back(32'sh10000);
      drain();
      write_size(2);
      queue_system(2, 2);
      queue_system(2, 1);
      drain();
      write_size(0);
      value_queue.push_back(32'sh8000); value_queue.push_back(32'shffff0000);
      drain();
      write_size(15);
      queue_system(8, 1);
      drain();
      // restart a partial load
      write_size(3);
      value_queue.push_back(32'sh1234);
      drain();
      sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         send_idle = (phase == 1 || phase == 3) ? (phase == 1 ? 84 : 30) : 0;
         recv_stall = (phase == 2 || phase == 3) ? (phase == 2 ? 84 : 30) : 0;
         while (sent < (phase + 1) * 85) begin
            n = ($urandom_range(9) == 0) ? 8 : $urandom_range(1, 4);
            write_size(n);
            queue_system(n, $urandom_range(9) < 6 ? 1 : ($urandom_range(1) ? 0 : 2));
            sent += n * (n + 1);
            drain();
         end
      end
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end
endmodule
